### sv/msvt_pkg.sv
// shared types, constants and fixed-point helpers for the vertex transform engine
package msvt_pkg;

  // default number of modelview matrices the push stack holds
  localparam int STACK_DEPTH_DEF = 32;

  // datapath widths
  localparam int FX_W   = 32;
  localparam int PROD_W = 64;
  localparam int ACC_W  = 68;
  localparam int DIVD_W = 49;
  localparam int QMAG_W = 48;

  // stream word widths
  localparam int IN_TDATA_W  = 88;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 104;
  localparam int OUT_TUSER_W = 3;

  // fixed-point constants
  localparam logic signed [FX_W-1:0] ONE_FX    = 32'sh0001_0000;
  localparam logic signed [FX_W-1:0] UNIT_INT  = 32'sd1;
  localparam logic signed [FX_W-1:0] W_MIN_RAW = 32'sd66;
  localparam logic signed [FX_W-1:0] SCALE_X   = 32'sd320;
  localparam logic signed [FX_W-1:0] SCALE_Y   = 32'sd240;
  localparam logic signed [FX_W-1:0] SCALE_Z   = 32'sd4096;

  // operation selector codes
  localparam logic [1:0] OP_ELEM   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_VERTEX = 2'd2;

  localparam logic [3:0] LAST_ELEM = 4'd15;

  // result status codes
  localparam logic [2:0] STAT_ELEM     = 3'd0;
  localparam logic [2:0] STAT_APPLIED  = 3'd1;
  localparam logic [2:0] STAT_PUSH_REJ = 3'd2;
  localparam logic [2:0] STAT_POP_REJ  = 3'd3;
  localparam logic [2:0] STAT_VTX_OK   = 3'd4;
  localparam logic [2:0] STAT_VTX_BAD  = 3'd5;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_APPLY,
    S_MUL,
    S_ACC,
    S_STORE,
    S_POP_RD,
    S_POP_WR,
    S_WCHK,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DONE
  } state_t;

  // what the multiply-accumulate unit is working on
  typedef enum logic [1:0] {
    J_MAT,
    J_EYE,
    J_CLIP
  } job_t;

  // divider request and response
  typedef struct packed {
    logic                     start;
    logic signed [DIVD_W-1:0] dividend;
    logic signed [FX_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [FX_W-1:0] quotient;
  } div_rsp_t;

  // clamp an accumulator value to 32 bits
  function automatic logic signed [FX_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [FX_W-1:0] r;
    if (&v[ACC_W-1:FX_W-1] || ~|v[ACC_W-1:FX_W-1]) begin
      r = v[FX_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  // round a 32.32 sum half up to 16.16 and clamp
  function automatic logic signed [FX_W-1:0] round_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + $signed({{(ACC_W-16){1'b0}}, 16'h8000});
    t = t >>> 16;
    return sat32(t);
  endfunction

  // identity matrix entry
  function automatic logic signed [FX_W-1:0] ident(input int i);
    return (i == 0 || i == 5 || i == 10 || i == 15) ? ONE_FX : '0;
  endfunction

endpackage

### sv/matrix_stack_vertex_transform.sv
// geometry engine: modelview/projection matrices, push stack and vertex transform
//
// One input channel (s_*) takes words of three kinds, chosen by s_tuser:
// matrix elements, modelview pops and vertices. Every input word gives exactly
// one result word on the output channel (m_*), status in m_tuser.
// Work per word, from accept to result ready:
//   matrix element 0..14: stored in staging only
//   element 15, load: staging copied; multiply onto target: 64 products on one
//   32x32 multiplier, plus a store per entry; a push first writes 16 stack entries
//   pop: one stack read ahead, then 16 register writes
//   vertex: three divides on the shared divider, plus up to 28 products
// The block takes one word at a time: s_tready is high only while idle.
// A finished result sits in the output register until taken; the next word
// may be accepted meanwhile, and its result waits until the register frees.
// Reset (rst, synchronous) sets both matrices to identity, empties the stack
// and marks both matrices absent; stack memory and staging are not cleared.
module matrix_stack_vertex_transform
  import msvt_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // element_index, matrix_element, to_projection, replace, push_first,
  // vertex_x, vertex_y, vertex_z, zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // operation
  input  logic [IN_TUSER_W-1:0]  s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // out_x, out_y, out_z, outside, zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // status
  output logic [OUT_TUSER_W-1:0] m_tuser
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH * 16);
  localparam int MEM_D  = STACK_DEPTH * 16;

  state_t state, state_next;
  job_t   job;

  // matrices and stack
  logic signed [FX_W-1:0] mv [16];
  logic signed [FX_W-1:0] pj [16];
  logic signed [FX_W-1:0] stg [16];
  logic signed [FX_W-1:0] stack_mem [MEM_D];
  logic signed [FX_W-1:0] rd_data;
  logic [CNT_W-1:0]       sp;
  logic                   mv_present;
  logic                   pj_present;

  // captured command
  logic        tp_q;
  logic        rep_q;
  logic signed [15:0] vx;
  logic signed [15:0] vy;
  logic signed [15:0] vz;
  logic [2:0]  status;

  // sequencing
  logic [3:0] cnt;
  logic [1:0] r;
  logic [1:0] c;
  logic [1:0] k;
  logic [1:0] dsel;

  // arithmetic
  logic signed [FX_W-1:0]   op_a;
  logic signed [FX_W-1:0]   op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [FX_W-1:0]   rowbuf [4];
  logic signed [FX_W-1:0]   eye_x;
  logic signed [FX_W-1:0]   eye_y;
  logic signed [FX_W-1:0]   eye_z;
  logic signed [FX_W-1:0]   clip [4];
  logic signed [FX_W-1:0]   res_x;
  logic signed [FX_W-1:0]   res_y;
  logic signed [FX_W-1:0]   res_z;

  // control helpers
  logic                   s_acc;
  logic                   out_free;
  logic                   push_ok;
  logic                   tgt_present;
  logic                   last_k;
  logic                   w_small;
  logic                   outside;
  logic [CNT_W+3:0]       addr_full;
  logic [ADDR_W-1:0]      mem_addr;
  logic                   mem_we;
  logic signed [FX_W-1:0] vk;
  logic signed [FX_W-1:0] vc;
  logic signed [FX_W-1:0] eye_k;
  logic signed [FX_W-1:0] tgt_rk;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  // input fields
  logic [1:0]             in_op;
  logic [3:0]             in_idx;
  logic signed [FX_W-1:0] in_elem;
  logic                   in_tp;
  logic                   in_rep;
  logic                   in_push;

  assign in_op   = s_tuser;
  assign in_idx  = s_tdata[3:0];
  assign in_elem = s_tdata[35:4];
  assign in_tp   = s_tdata[36];
  assign in_rep  = s_tdata[37];
  assign in_push = s_tdata[38];

  assign s_acc       = s_tvalid && s_tready;
  assign out_free    = !m_tvalid || m_tready;
  assign push_ok     = !in_tp && in_push && (sp < CNT_W'(STACK_DEPTH));
  assign tgt_present = tp_q ? pj_present : mv_present;
  assign last_k      = (job == J_EYE && !mv_present) ? (k == 2'd0) : (k == 2'd3);
  assign w_small     = (clip[3] > -W_MIN_RAW) && (clip[3] < W_MIN_RAW);
  assign outside     = (status == STAT_VTX_OK) &&
                       (res_x < -ONE_FX || res_x > ONE_FX ||
                        res_y < -ONE_FX || res_y > ONE_FX ||
                        res_z < -ONE_FX || res_z > ONE_FX);
  // pop reads one entry ahead of the register being written
  assign addr_full   = {sp, (state == S_POP_WR) ? cnt + 4'd1 : cnt};
  assign mem_addr    = addr_full[ADDR_W-1:0];

  // operand selection for the multiplier
  always_comb begin
    unique case (k)
      2'd0:    vk = {{16{vx[15]}}, vx};
      2'd1:    vk = {{16{vy[15]}}, vy};
      default: vk = {{16{vz[15]}}, vz};
    endcase
    unique case (c)
      2'd0:    vc = {{16{vx[15]}}, vx};
      2'd1:    vc = {{16{vy[15]}}, vy};
      default: vc = {{16{vz[15]}}, vz};
    endcase
    unique case (k)
      2'd0:    eye_k = eye_x;
      2'd1:    eye_k = eye_y;
      default: eye_k = eye_z;
    endcase
    tgt_rk = tp_q ? pj[{r, k}] : mv[{r, k}];
    op_a = '0;
    op_b = '0;
    unique case (job)
      J_MAT: begin
        op_a = tgt_rk;
        op_b = stg[{k, c}];
      end
      J_EYE: begin
        if (!mv_present) begin
          op_a = vc;
          op_b = ONE_FX;
        end else if (k == 2'd3) begin
          op_a = mv[{2'd3, c}];
          op_b = UNIT_INT;
        end else begin
          op_a = vk;
          op_b = mv[{k, c}];
        end
      end
      J_CLIP: begin
        if (k == 2'd3) begin
          op_a = pj[{2'd3, c}];
          op_b = ONE_FX;
        end else begin
          op_a = eye_k;
          op_b = pj[{k, c}];
        end
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_acc) begin
          unique case (in_op)
            OP_ELEM: begin
              if (in_idx != LAST_ELEM) begin
                state_next = S_DONE;
              end else if (push_ok) begin
                state_next = S_PUSH;
              end else begin
                state_next = S_APPLY;
              end
            end
            OP_POP:    state_next = (sp == '0) ? S_DONE : S_POP_RD;
            OP_VERTEX: state_next = S_MUL;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_PUSH:   if (cnt == 4'd15) state_next = S_APPLY;
      S_APPLY:  state_next = (!rep_q && tgt_present) ? S_MUL : S_DONE;
      S_MUL:    state_next = S_ACC;
      S_ACC:    state_next = last_k ? S_STORE : S_MUL;
      S_STORE: begin
        unique case (job)
          J_MAT:  state_next = (r == 2'd3 && c == 2'd3) ? S_DONE : S_MUL;
          J_EYE: begin
            if (c != 2'd2) begin
              state_next = S_MUL;
            end else begin
              state_next = pj_present ? S_MUL : S_DIV_GO;
            end
          end
          J_CLIP:  state_next = (c == 2'd3) ? S_WCHK : S_MUL;
          default: state_next = S_DONE;
        endcase
      end
      S_POP_RD:   state_next = S_POP_WR;
      S_POP_WR:   if (cnt == 4'd15) state_next = S_DONE;
      S_WCHK:     state_next = w_small ? S_DONE : S_DIV_GO;
      S_DIV_GO:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: if (div_rsp.done) state_next = (dsel == 2'd2) ? S_DONE : S_DIV_GO;
      S_DONE:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready = (state == S_IDLE);
    mem_we   = (state == S_PUSH);
    div_req.start = (state == S_DIV_GO);
    if (pj_present) begin
      div_req.dividend = $signed({clip[dsel][FX_W-1], clip[dsel], 16'h0000});
      div_req.divisor  = clip[3];
    end else begin
      unique case (dsel)
        2'd0: begin
          div_req.dividend = $signed({{(DIVD_W-FX_W){eye_x[FX_W-1]}}, eye_x});
          div_req.divisor  = SCALE_X;
        end
        2'd1: begin
          div_req.dividend = -$signed({{(DIVD_W-FX_W){eye_y[FX_W-1]}}, eye_y});
          div_req.divisor  = SCALE_Y;
        end
        default: begin
          div_req.dividend = $signed({{(DIVD_W-FX_W){eye_z[FX_W-1]}}, eye_z});
          div_req.divisor  = SCALE_Z;
        end
      endcase
    end
  end

  msvt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // stack memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_addr] <= mv[cnt];
    end
    rd_data <= stack_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // architectural state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        mv[i] <= ident(i);
        pj[i] <= ident(i);
      end
      sp         <= '0;
      mv_present <= 1'b0;
      pj_present <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // result register: load when done, clear when taken
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_acc && in_op == OP_POP && sp != '0) begin
            sp <= sp - 1'b1;
          end
        end
        S_PUSH: begin
          if (cnt == 4'd15) begin
            sp <= sp + 1'b1;
          end
        end
        S_APPLY: begin
          if (rep_q || !tgt_present) begin
            if (tp_q) begin
              pj         <= stg;
              pj_present <= 1'b1;
            end else begin
              mv         <= stg;
              mv_present <= 1'b1;
            end
          end
        end
        S_STORE: begin
          if (job == J_MAT && c == 2'd3) begin
            for (int j = 0; j < 3; j++) begin
              if (tp_q) begin
                pj[{r, 2'(j)}] <= rowbuf[j];
              end else begin
                mv[{r, 2'(j)}] <= rowbuf[j];
              end
            end
            if (tp_q) begin
              pj[{r, 2'd3}] <= round_sat(acc);
            end else begin
              mv[{r, 2'd3}] <= round_sat(acc);
            end
          end
        end
        S_POP_WR: begin
          mv[cnt] <= rd_data;
          if (cnt == 4'd15) begin
            mv_present <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (s_acc) begin
          tp_q  <= in_tp;
          rep_q <= in_rep;
          vx    <= s_tdata[54:39];
          vy    <= s_tdata[70:55];
          vz    <= s_tdata[86:71];
          res_x <= '0;
          res_y <= '0;
          res_z <= '0;
          cnt   <= '0;
          r     <= '0;
          c     <= '0;
          k     <= '0;
          acc   <= '0;
          job   <= J_EYE;
          unique case (in_op)
            OP_ELEM: begin
              stg[in_idx] <= in_elem;
              if (in_idx != LAST_ELEM) begin
                status <= STAT_ELEM;
              end else if (!in_tp && in_push && !push_ok) begin
                status <= STAT_PUSH_REJ;
              end else begin
                status <= STAT_APPLIED;
              end
            end
            OP_POP:    status <= (sp == '0) ? STAT_POP_REJ : STAT_APPLIED;
            OP_VERTEX: status <= STAT_VTX_OK;
            default:   status <= STAT_ELEM;
          endcase
        end
      end
      S_PUSH: cnt <= cnt + 1'b1;
      S_APPLY: begin
        job <= J_MAT;
        r   <= '0;
        c   <= '0;
        k   <= '0;
        acc <= '0;
      end
      S_MUL: prod <= op_a * op_b;
      S_ACC: begin
        acc <= acc + $signed({{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod});
        k   <= k + 1'b1;
      end
      S_STORE: begin
        acc  <= '0;
        k    <= '0;
        dsel <= '0;
        unique case (job)
          J_MAT: begin
            rowbuf[c] <= round_sat(acc);
            c <= c + 1'b1;
            if (c == 2'd3) begin
              r <= r + 1'b1;
            end
          end
          J_EYE: begin
            unique case (c)
              2'd0:    eye_x <= sat32(acc);
              2'd1:    eye_y <= sat32(acc);
              default: eye_z <= sat32(acc);
            endcase
            if (c == 2'd2) begin
              c   <= '0;
              job <= J_CLIP;
            end else begin
              c <= c + 1'b1;
            end
          end
          J_CLIP: begin
            clip[c] <= round_sat(acc);
            c <= c + 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_POP_WR: cnt <= cnt + 1'b1;
      S_WCHK: begin
        if (w_small) begin
          status <= STAT_VTX_BAD;
        end
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          unique case (dsel)
            2'd0:    res_x <= div_rsp.quotient;
            2'd1:    res_y <= div_rsp.quotient;
            default: res_z <= div_rsp.quotient;
          endcase
          dsel <= dsel + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          m_tuser <= status;
          m_tdata <= {7'b0, outside, res_z, res_y, res_x};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### sv/msvt_div.sv
// signed restoring divider, one quotient bit a cycle, truncating and saturating
module msvt_div
  import msvt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(QMAG_W + 1);

  logic              busy;
  logic              done;
  logic              neg;
  logic [CNT_W-1:0]  cnt;
  logic [FX_W-1:0]   dmag;
  logic [FX_W-1:0]   rem;
  logic [QMAG_W-1:0] quo;
  logic [FX_W:0]     trial;
  logic [DIVD_W-1:0] nmag_full;
  logic [FX_W:0]     dmag_full;

  // operand magnitudes
  always_comb begin
    nmag_full = req.dividend[DIVD_W-1] ? DIVD_W'(-req.dividend) : req.dividend;
    dmag_full = req.divisor[FX_W-1] ? -{req.divisor[FX_W-1], req.divisor}
                                    : {1'b0, req.divisor};
    trial     = {rem, quo[QMAG_W-1]};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(QMAG_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // shift-subtract datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt  <= '0;
      rem  <= '0;
      quo  <= nmag_full[QMAG_W-1:0];
      dmag <= dmag_full[FX_W-1:0];
      neg  <= req.dividend[DIVD_W-1] ^ req.divisor[FX_W-1];
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (trial >= {1'b0, dmag}) begin
        rem <= FX_W'(trial - {1'b0, dmag});
        quo <= {quo[QMAG_W-2:0], 1'b1};
      end else begin
        rem <= trial[FX_W-1:0];
        quo <= {quo[QMAG_W-2:0], 1'b0};
      end
    end
  end

  // sign and clamp the quotient
  always_comb begin
    rsp.done = done;
    if (neg) begin
      if (quo > QMAG_W'(33'h0_8000_0000)) begin
        rsp.quotient = 32'sh8000_0000;
      end else begin
        rsp.quotient = FX_W'(-quo);
      end
    end else begin
      if (quo > QMAG_W'(32'h7fff_ffff)) begin
        rsp.quotient = 32'sh7fff_ffff;
      end else begin
        rsp.quotient = quo[FX_W-1:0];
      end
    end
  end

endmodule

### sv/msvt_checker.sv
// port-level checks for the vertex transform engine, bound to the top level
module msvt_checker
  import msvt_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [IN_TDATA_W-1:0]  s_tdata,
  input logic [IN_TUSER_W-1:0]  s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic [OUT_TUSER_W-1:0] m_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

  // only a valid vertex carries coordinates or the outside flag
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != STAT_VTX_OK |-> m_tdata == '0)
    else $error("non-vertex result carries data");

  // an accepted word keeps the input closed for the next cycle
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready straight after accept");

endmodule

bind matrix_stack_vertex_transform msvt_checker u_chk (.*);
